/* hdl/ppbw_pkg.sv */
// ----------------------------------------------------------------------------
// ppbw_pkg
// Shared widths, register indexes and sideband types of the projection core.
// ----------------------------------------------------------------------------
package ppbw_pkg;

  localparam int unsigned MAT_W = 32;  // Q12.20 matrix entry
  localparam int unsigned PT_W  = 32;  // Q16.16 point coordinate
  localparam int unsigned ACC_W = 64;  // row sum width
  localparam int unsigned MAG_W = 63;  // magnitude of a row sum
  localparam int unsigned CFG_W = 64;  // configuration data width
  localparam int unsigned DIM_W = 13;  // image dimension width
  localparam int unsigned IDX_W = 3;   // configuration index width
  localparam int unsigned NUM_PROJ = 6;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5,
    REG_ROWS   = 3'd6,
    REG_COLS   = 3'd7
  } ppbw_reg_e;

  // Sign and zero information that rides along the divider
  typedef struct packed {
    logic zero_den;
    logic neg_u;
    logic neg_v;
  } ppbw_flags_t;

  typedef logic [NUM_PROJ-1:0][CFG_W-1:0] ppbw_matrix_t;

  // Magnitude of a row sum; row sums never exceed 2^62 in magnitude
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] t;
    t = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    return t[MAG_W-1:0];
  endfunction

endpackage

/* hdl/ppbw_matrix.sv */
// ----------------------------------------------------------------------------
// ppbw_matrix
// Four-stage matrix-vector product: multiply, pair sums, row sums, magnitude.
// ----------------------------------------------------------------------------
module ppbw_matrix
  import ppbw_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [PT_W-1:0]   point_x_i,
  input  logic signed [PT_W-1:0]   point_y_i,
  input  logic signed [PT_W-1:0]   point_z_i,
  input  logic signed [PT_W-1:0]   point_w_i,
  input  ppbw_matrix_t             mat_i,
  output logic                     valid_o,
  output ppbw_flags_t              flags_o,
  output logic [MAG_W-1:0]         num_u_o,
  output logic [MAG_W-1:0]         num_v_o,
  output logic [MAG_W-1:0]         den_o
);

  logic signed [PT_W-1:0]  pt [4];
  logic signed [ACC_W-1:0] prod_q [3][4];
  logic signed [ACC_W-1:0] pair_q [3][2];
  logic signed [ACC_W-1:0] sum_q  [3];
  logic [3:0]              vld_q;
  ppbw_flags_t             flags_q;
  logic [MAG_W-1:0]        num_u_q, num_v_q, den_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign pt[3] = point_w_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Multiply, then sum pairs of floor-quartered products, then rows
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[r][c] <= $signed(mat_i[2*r + c/2][MAT_W*(c%2) +: MAT_W]) * pt[c];
      end
      for (int h = 0; h < 2; h++) begin
        pair_q[r][h] <= (prod_q[r][2*h] >>> 2) + (prod_q[r][2*h+1] >>> 2);
      end
      sum_q[r] <= pair_q[r][0] + pair_q[r][1];
    end
  end

  // Split into magnitudes and signs for the divider
  always_ff @(posedge clk_i) begin
    num_u_q          <= mag_of(sum_q[0]);
    num_v_q          <= mag_of(sum_q[1]);
    den_q            <= mag_of(sum_q[2]);
    flags_q.zero_den <= (sum_q[2] == '0);
    flags_q.neg_u    <= sum_q[0][ACC_W-1] ^ sum_q[2][ACC_W-1];
    flags_q.neg_v    <= sum_q[1][ACC_W-1] ^ sum_q[2][ACC_W-1];
  end

  assign valid_o = vld_q[3];
  assign flags_o = flags_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign den_o   = den_q;

endmodule

/* hdl/ppbw_div_pipe.sv */
// ----------------------------------------------------------------------------
// ppbw_div_pipe
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share a denominator. Quotient carries FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module ppbw_div_pipe
  import ppbw_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  ppbw_flags_t                    flags_i,
  input  logic [MAG_W-1:0]               num_u_i,
  input  logic [MAG_W-1:0]               num_v_i,
  input  logic [MAG_W-1:0]               den_i,
  output logic                           valid_o,
  output ppbw_flags_t                    flags_o,
  output logic [MAG_W+FRAC_BITS-1:0]     quo_u_o,
  output logic [MAG_W+FRAC_BITS-1:0]     quo_v_o,
  output logic                           rnz_u_o,
  output logic                           rnz_v_o
);

  localparam int unsigned DW = MAG_W + FRAC_BITS;

  logic              vld_q   [DW];
  ppbw_flags_t       flags_q [DW];
  logic [MAG_W-1:0]  num_u_q [DW];
  logic [MAG_W-1:0]  num_v_q [DW];
  logic [MAG_W-1:0]  den_q   [DW];
  logic [MAG_W-1:0]  rem_u_q [DW];
  logic [MAG_W-1:0]  rem_v_q [DW];
  logic [DW-1:0]     quo_u_q [DW];
  logic [DW-1:0]     quo_v_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic              in_vld;
    ppbw_flags_t       in_flags;
    logic [MAG_W-1:0]  in_num_u, in_num_v, in_den, in_rem_u, in_rem_v;
    logic [DW-1:0]     in_quo_u, in_quo_v;
    logic              nb_u, nb_v, ge_u, ge_v;
    logic [MAG_W:0]    trial_u, trial_v, den_x;

    if (k == 0) begin : g_first
      assign in_vld   = valid_i;
      assign in_flags = flags_i;
      assign in_num_u = num_u_i;
      assign in_num_v = num_v_i;
      assign in_den   = den_i;
      assign in_rem_u = '0;
      assign in_rem_v = '0;
      assign in_quo_u = '0;
      assign in_quo_v = '0;
    end else begin : g_next
      assign in_vld   = vld_q[k-1];
      assign in_flags = flags_q[k-1];
      assign in_num_u = num_u_q[k-1];
      assign in_num_v = num_v_q[k-1];
      assign in_den   = den_q[k-1];
      assign in_rem_u = rem_u_q[k-1];
      assign in_rem_v = rem_v_q[k-1];
      assign in_quo_u = quo_u_q[k-1];
      assign in_quo_v = quo_v_q[k-1];
    end

    // Bring down the next dividend bit; fraction bits bring down zero
    if (k < MAG_W) begin : g_int
      assign nb_u = in_num_u[MAG_W-1-k];
      assign nb_v = in_num_v[MAG_W-1-k];
    end else begin : g_frac
      assign nb_u = 1'b0;
      assign nb_v = 1'b0;
    end

    assign den_x   = {1'b0, in_den};
    assign trial_u = {in_rem_u, nb_u};
    assign trial_v = {in_rem_v, nb_v};
    assign ge_u    = (trial_u >= den_x);
    assign ge_v    = (trial_v >= den_x);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= in_vld;
      end
    end

    // Subtract where it fits and shift in the quotient bit
    always_ff @(posedge clk_i) begin
      flags_q[k] <= in_flags;
      num_u_q[k] <= in_num_u;
      num_v_q[k] <= in_num_v;
      den_q[k]   <= in_den;
      rem_u_q[k] <= ge_u ? MAG_W'(trial_u - den_x) : trial_u[MAG_W-1:0];
      rem_v_q[k] <= ge_v ? MAG_W'(trial_v - den_x) : trial_v[MAG_W-1:0];
      quo_u_q[k] <= {in_quo_u[DW-2:0], ge_u};
      quo_v_q[k] <= {in_quo_v[DW-2:0], ge_v};
    end
  end

  assign valid_o = vld_q[DW-1];
  assign flags_o = flags_q[DW-1];
  assign quo_u_o = quo_u_q[DW-1];
  assign quo_v_o = quo_v_q[DW-1];
  assign rnz_u_o = (rem_u_q[DW-1] != '0);
  assign rnz_v_o = (rem_v_q[DW-1] != '0);

endmodule

/* hdl/ppbw_finish.sv */
// ----------------------------------------------------------------------------
// ppbw_finish
// Floor correction, saturation and bounds check, then bilinear weights.
// ----------------------------------------------------------------------------
module ppbw_finish
  import ppbw_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  ppbw_flags_t                       flags_i,
  input  logic [MAG_W+FRAC_BITS-1:0]        quo_u_i,
  input  logic [MAG_W+FRAC_BITS-1:0]        quo_v_i,
  input  logic                              rnz_u_i,
  input  logic                              rnz_v_i,
  input  logic [DIM_W-1:0]                  image_rows_i,
  input  logic [DIM_W-1:0]                  image_cols_i,
  output logic                              valid_o,
  output logic signed [PIXEL_BITS-1:0]      pixel_u_o,
  output logic signed [PIXEL_BITS-1:0]      pixel_v_o,
  output logic [FRAC_BITS:0]                weight_00_o,
  output logic [FRAC_BITS:0]                weight_10_o,
  output logic [FRAC_BITS:0]                weight_01_o,
  output logic [FRAC_BITS:0]                weight_11_o,
  output logic                              in_bounds_o
);

  localparam int unsigned DW = MAG_W + FRAC_BITS;
  localparam int unsigned WW = FRAC_BITS + 1;
  localparam logic [MAG_W-1:0] HI_M = (MAG_W'(1) << (PIXEL_BITS - 1)) - MAG_W'(1);
  localparam logic [MAG_W:0]   LO_M = (MAG_W+1)'(1) << (PIXEL_BITS - 1);
  localparam logic [WW-1:0]    ONE  = WW'(1) << FRAC_BITS;

  logic [DW-1:0]         quo [2];
  logic                  rnz [2];
  logic                  neg [2];
  logic [DIM_W-1:0]      dim [2];
  logic [PIXEL_BITS-1:0] pix_d  [2];
  logic [FRAC_BITS-1:0]  frac_d [2];
  logic                  ok_d   [2];

  assign quo[0] = quo_u_i;
  assign quo[1] = quo_v_i;
  assign rnz[0] = rnz_u_i;
  assign rnz[1] = rnz_v_i;
  assign neg[0] = flags_i.neg_u;
  assign neg[1] = flags_i.neg_v;
  assign dim[0] = image_cols_i;
  assign dim[1] = image_rows_i;

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic [MAG_W-1:0]      q;
    logic [FRAC_BITS-1:0]  f;
    logic                  fs, negr, lim_ok;
    logic [MAG_W:0]        mag, mag_sat;
    logic [DIM_W:0]        lim;
    logic [PIXEL_BITS-1:0] pos_pix, neg_pix;
    logic [FRAC_BITS-1:0]  neg_frac;

    assign q        = quo[a][DW-1:FRAC_BITS];
    assign f        = quo[a][FRAC_BITS-1:0];
    assign fs       = (f != '0) || rnz[a];
    assign negr     = neg[a] && ((q != '0) || fs);
    // Round the magnitude up for a negative quotient, then clamp
    assign mag      = {1'b0, q} + (MAG_W+1)'(fs);
    assign mag_sat  = (mag > LO_M) ? LO_M : mag;
    assign neg_pix  = PIXEL_BITS'(0) - mag_sat[PIXEL_BITS-1:0];
    assign neg_frac = FRAC_BITS'(0) - f - FRAC_BITS'(rnz[a]);
    assign pos_pix  = (q > HI_M) ? HI_M[PIXEL_BITS-1:0] : q[PIXEL_BITS-1:0];
    assign lim      = {1'b0, dim[a]} - (DIM_W+1)'(2);
    assign lim_ok   = !lim[DIM_W] && (lim != '0) && (q < MAG_W'(lim[DIM_W-1:0]));

    assign pix_d[a]  = negr ? neg_pix : pos_pix;
    assign frac_d[a] = negr ? neg_frac : f;
    assign ok_d[a]   = !negr && lim_ok;
  end

  // Stage A: corrected coordinates and fractions
  logic                  vld_a_q, vld_b_q;
  logic                  zero_a_q;
  logic [PIXEL_BITS-1:0] pix_u_q, pix_v_q;
  logic [FRAC_BITS-1:0]  fu_q, fv_q;
  logic                  ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  // Drop everything to zero on a zero denominator
  always_ff @(posedge clk_i) begin
    zero_a_q <= flags_i.zero_den;
    pix_u_q  <= flags_i.zero_den ? '0 : pix_d[0];
    pix_v_q  <= flags_i.zero_den ? '0 : pix_d[1];
    fu_q     <= flags_i.zero_den ? '0 : frac_d[0];
    fv_q     <= flags_i.zero_den ? '0 : frac_d[1];
    ok_q     <= !flags_i.zero_den && ok_d[0] && ok_d[1];
  end

  // Stage B: weight products, keep FRAC_BITS fraction bits
  logic [WW-1:0]   au, av, fu_x, fv_x;
  logic [2*WW-1:0] p00, p10, p01, p11;

  assign fu_x = {1'b0, fu_q};
  assign fv_x = {1'b0, fv_q};
  assign au   = ONE - fu_x;
  assign av   = ONE - fv_x;
  assign p00  = au * av;
  assign p10  = fu_x * av;
  assign p01  = au * fv_x;
  assign p11  = fu_x * fv_x;

  logic signed [PIXEL_BITS-1:0] pu_out_q, pv_out_q;
  logic [WW-1:0]                w00_q, w10_q, w01_q, w11_q;
  logic                         inb_q;

  always_ff @(posedge clk_i) begin
    pu_out_q <= pix_u_q;
    pv_out_q <= pix_v_q;
    w00_q    <= zero_a_q ? '0 : p00[2*FRAC_BITS:FRAC_BITS];
    w10_q    <= zero_a_q ? '0 : p10[2*FRAC_BITS:FRAC_BITS];
    w01_q    <= zero_a_q ? '0 : p01[2*FRAC_BITS:FRAC_BITS];
    w11_q    <= zero_a_q ? '0 : p11[2*FRAC_BITS:FRAC_BITS];
    inb_q    <= ok_q;
  end

  assign valid_o     = vld_b_q;
  assign pixel_u_o   = pu_out_q;
  assign pixel_v_o   = pv_out_q;
  assign weight_00_o = w00_q;
  assign weight_10_o = w10_q;
  assign weight_01_o = w01_q;
  assign weight_11_o = w11_q;
  assign in_bounds_o = inb_q;

endmodule

/* hdl/perspective_project_bilinear_weights_core.sv */
// Path: a point taken on start_i passes through the matrix product, then the
//   long-division pipe, one quotient bit per stage over 63 + FRAC_BITS stages,
//   then the finish block, and its result strobes on done_o.
// Throughput: one point per cycle; busy_o stays low and the receiver cannot stall.
// Reset: asynchronous, active low; clears all valid bits and loads the matrix
//   with zeros and the image size with 640 x 480.
// ----------------------------------------------------------------------------
// perspective_project_bilinear_weights_core
// Projects homogeneous points through a 3x4 matrix and returns floored pixel
// coordinates, bilinear weights and an in-bounds flag.
// ----------------------------------------------------------------------------
module perspective_project_bilinear_weights_core
  import ppbw_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [PT_W-1:0]        point_x_i,
  input  logic signed [PT_W-1:0]        point_y_i,
  input  logic signed [PT_W-1:0]        point_z_i,
  input  logic signed [PT_W-1:0]        point_w_i,
  input  logic                          cfg_we_i,
  input  logic [IDX_W-1:0]              cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  output logic                          done_o,
  output logic signed [PIXEL_BITS-1:0]  pixel_u_o,
  output logic signed [PIXEL_BITS-1:0]  pixel_v_o,
  output logic [FRAC_BITS:0]            weight_00_o,
  output logic [FRAC_BITS:0]            weight_10_o,
  output logic [FRAC_BITS:0]            weight_01_o,
  output logic [FRAC_BITS:0]            weight_11_o,
  output logic                          in_bounds_o
);

  localparam int unsigned DW  = MAG_W + FRAC_BITS;
  localparam int unsigned LAT = DW + 6;

  ppbw_matrix_t     proj_q;
  logic [DIM_W-1:0] rows_q, cols_q;
  ppbw_reg_e        cfg_reg;

  assign cfg_reg = ppbw_reg_e'(cfg_idx_i);
  assign busy_o  = 1'b0;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_q <= '0;
      rows_q <= DIM_W'(480);
      cols_q <= DIM_W'(640);
    end else if (cfg_we_i) begin
      unique case (cfg_reg) inside
        REG_ROW0_A, REG_ROW0_B, REG_ROW1_A,
        REG_ROW1_B, REG_ROW2_A, REG_ROW2_B: proj_q[cfg_idx_i] <= cfg_wdata_i;
        REG_ROWS: rows_q <= cfg_wdata_i[DIM_W-1:0];
        REG_COLS: cols_q <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic             mx_valid;
  ppbw_flags_t      mx_flags;
  logic [MAG_W-1:0] mx_num_u, mx_num_v, mx_den;

  ppbw_matrix u_matrix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .point_w_i (point_w_i),
    .mat_i     (proj_q),
    .valid_o   (mx_valid),
    .flags_o   (mx_flags),
    .num_u_o   (mx_num_u),
    .num_v_o   (mx_num_v),
    .den_o     (mx_den)
  );

  logic          dv_valid;
  ppbw_flags_t   dv_flags;
  logic [DW-1:0] dv_quo_u, dv_quo_v;
  logic          dv_rnz_u, dv_rnz_v;

  ppbw_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mx_valid),
    .flags_i (mx_flags),
    .num_u_i (mx_num_u),
    .num_v_i (mx_num_v),
    .den_i   (mx_den),
    .valid_o (dv_valid),
    .flags_o (dv_flags),
    .quo_u_o (dv_quo_u),
    .quo_v_o (dv_quo_v),
    .rnz_u_o (dv_rnz_u),
    .rnz_v_o (dv_rnz_v)
  );

  ppbw_finish #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (dv_valid),
    .flags_i      (dv_flags),
    .quo_u_i      (dv_quo_u),
    .quo_v_i      (dv_quo_v),
    .rnz_u_i      (dv_rnz_u),
    .rnz_v_i      (dv_rnz_v),
    .image_rows_i (rows_q),
    .image_cols_i (cols_q),
    .valid_o      (done_o),
    .pixel_u_o    (pixel_u_o),
    .pixel_v_o    (pixel_v_o),
    .weight_00_o  (weight_00_o),
    .weight_10_o  (weight_10_o),
    .weight_01_o  (weight_01_o),
    .weight_11_o  (weight_11_o),
    .in_bounds_o  (in_bounds_o)
  );

  // Every accepted transfer in is matched by a later result strobe
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT done_o)
    else $error("result strobe missing after accepted point");

  // No strobe without a matching transfer in
  a_lat_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without accepted point");

  // An in-bounds result never carries a negative coordinate
  a_inb_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && in_bounds_o |-> !pixel_u_o[PIXEL_BITS-1] && !pixel_v_o[PIXEL_BITS-1])
    else $error("in-bounds result with negative pixel");

endmodule

/* test/ppbw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppbw_checker
// Watches the point, register and result channels of the projection core.
// Predicts each result from its own copy of the matrix and image size and
// compares it field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module ppbw_checker
  import ppbw_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic signed [PT_W-1:0]   point_x_i,
  input  logic signed [PT_W-1:0]   point_y_i,
  input  logic signed [PT_W-1:0]   point_z_i,
  input  logic signed [PT_W-1:0]   point_w_i,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     done_i,
  input  logic signed [15:0]       pixel_u_i,
  input  logic signed [15:0]       pixel_v_i,
  input  logic [16:0]              weight_00_i,
  input  logic [16:0]              weight_10_i,
  input  logic [16:0]              weight_01_i,
  input  logic [16:0]              weight_11_i,
  input  logic                     in_bounds_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [15:0] u;
    logic [15:0] v;
    logic [16:0] w00;
    logic [16:0] w10;
    logic [16:0] w01;
    logic [16:0] w11;
    logic        ib;
  } pixel_t;

  logic [CFG_W-1:0] mat_q [NUM_PROJ];
  logic [DIM_W-1:0] rows_q, cols_q;
  pixel_t           expected_pixels [$];

  // Sum of one matrix row times the point, each product floored by 4
  function automatic logic signed [63:0] row_dot(input int r,
                                                 input logic signed [63:0] pt [4]);
    logic signed [63:0] s, me;
    logic [31:0] e;
    s = 0;
    for (int c = 0; c < 4; c++) begin
      e = mat_q[2 * r + c / 2][32 * (c % 2) +: 32];
      me = $signed(e);
      s += (me * pt[c]) >>> 2;
    end
    return s;
  endfunction

  // Floored quotient: saturated pixel, fraction and bound check
  function automatic void floor_divide(input logic signed [63:0] num, den, lim,
                                       output logic [15:0] pix,
                                       output logic [15:0] frac, output logic ok);
    logic [63:0] an, ad, q, r, f, s, mag;
    logic neg;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = an / ad;
    r = an % ad;
    f = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= ad) begin
        r -= ad;
        f |= 1;
      end
    end
    s = 64'(r != 0);
    neg = ((num < 0) != (den < 0)) && ((q | f | s) != 0);
    if (!neg) begin
      frac = f[15:0];
      pix = q > 32767 ? 16'd32767 : q[15:0];
      ok = lim > 0 && q < lim;
    end else begin
      mag = q + ((f | s) != 0);
      frac = 16'(0 - f - s);
      if (mag > 32768) mag = 32768;
      pix = 16'(0 - mag);
      ok = 1'b0;
    end
  endfunction

  function automatic pixel_t project_point(input logic signed [31:0] x, y, z, w);
    logic signed [63:0] pt [4];
    logic signed [63:0] nx, ny, d;
    logic [15:0] fu, fv;
    logic [16:0] a, b;
    logic [33:0] p;
    logic ok_u, ok_v;
    pixel_t res;
    pt[0] = x; pt[1] = y; pt[2] = z; pt[3] = w;
    nx = row_dot(0, pt);
    ny = row_dot(1, pt);
    d = row_dot(2, pt);
    res = '0;
    if (d == 0) return res;
    floor_divide(nx, d, $signed({51'd0, cols_q}) - 2, res.u, fu, ok_u);
    floor_divide(ny, d, $signed({51'd0, rows_q}) - 2, res.v, fv, ok_v);
    a = 17'h10000 - fu;
    b = 17'h10000 - fv;
    p = a * b;  res.w00 = p[32:16];
    p = fu * b; res.w10 = p[32:16];
    p = a * fv; res.w01 = p[32:16];
    p = fu * fv; res.w11 = p[32:16];
    res.ib = ok_u && ok_v;
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] got, exp);
    $display("%0t: %s mismatch: got %0h expected %0h", $realtime, field, got, exp);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  // Track register writes, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t exp_px;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PROJ; i++) mat_q[i] = '0;
      rows_q = 13'd480;
      cols_q = 13'd640;
      expected_pixels.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (ppbw_reg_e'(cfg_idx_i))
          REG_ROWS: rows_q = cfg_wdata_i[DIM_W-1:0];
          REG_COLS: cols_q = cfg_wdata_i[DIM_W-1:0];
          default:  mat_q[cfg_idx_i] = cfg_wdata_i;
        endcase
      end
      if (done_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with no point pending", $realtime);
          fail_count_o++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (pixel_u_i !== exp_px.u) report("pixel_u", pixel_u_i, exp_px.u);
          if (pixel_v_i !== exp_px.v) report("pixel_v", pixel_v_i, exp_px.v);
          if (weight_00_i !== exp_px.w00) report("weight_00", weight_00_i, exp_px.w00);
          if (weight_10_i !== exp_px.w10) report("weight_10", weight_10_i, exp_px.w10);
          if (weight_01_i !== exp_px.w01) report("weight_01", weight_01_i, exp_px.w01);
          if (weight_11_i !== exp_px.w11) report("weight_11", weight_11_i, exp_px.w11);
          if (in_bounds_i !== exp_px.ib) report("in_bounds", in_bounds_i, exp_px.ib);
        end
      end
      if (start_i && !busy_i)
        expected_pixels.push_back(project_point(point_x_i, point_y_i, point_z_i,
                                                point_w_i));
      pending_o = expected_pixels.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives points and matrix settings into the projection core under several
// camera setups, image sizes and idle patterns; the checker predicts results.
// ----------------------------------------------------------------------------
module tb_top
  import ppbw_pkg::*;
;

  localparam int LATENCY = 90;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [31:0] ONE_M = 32'h0010_0000;  // 1.0 in Q12.20
  localparam logic [31:0] ONE_P = 32'h0001_0000;  // 1.0 in Q16.16

  logic clk, rst_n, start, busy, cfg_we, done, in_bounds;
  logic signed [PT_W-1:0] px, py, pz, pw;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic signed [15:0] pixel_u, pixel_v;
  logic [16:0] w00, w10, w01, w11;
  int fail_count, pending, cycles, idle_pct;

  perspective_project_bilinear_weights_core dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .point_x_i(px), .point_y_i(py), .point_z_i(pz), .point_w_i(pw),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .done_o(done), .pixel_u_o(pixel_u), .pixel_v_o(pixel_v),
    .weight_00_o(w00), .weight_10_o(w10), .weight_01_o(w01), .weight_11_o(w11),
    .in_bounds_o(in_bounds)
  );

  ppbw_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .point_x_i(px), .point_y_i(py), .point_z_i(pz), .point_w_i(pw),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .done_i(done), .pixel_u_i(pixel_u), .pixel_v_i(pixel_v),
    .weight_00_i(w00), .weight_10_i(w10), .weight_01_i(w01), .weight_11_i(w11),
    .in_bounds_i(in_bounds), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run at a generous cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("perspective_project_bilinear_weights_core test failed");
      $finish;
    end
  end

  task automatic write_reg(input ppbw_reg_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load a camera: focal lengths and center in whole pixels
  task automatic load_camera(input int fx, fy, cx, cy);
    write_reg(REG_ROW0_A, {32'd0, 32'(fx <<< 20)});
    write_reg(REG_ROW0_B, {32'd0, 32'(cx <<< 20)});
    write_reg(REG_ROW1_A, {32'(fy <<< 20), 32'd0});
    write_reg(REG_ROW1_B, {32'd0, 32'(cy <<< 20)});
    write_reg(REG_ROW2_A, 64'd0);
    write_reg(REG_ROW2_B, {32'd0, ONE_M});
  endtask

  // Hold off until every result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Transfer one point; start stays high into the next call unless idling
  task automatic send_point(input logic [31:0] x, y, z, w);
    logic took;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    start <= 1'b1;
    px <= x; py <= y; pz <= z; pw <= w;
    forever begin
      took = !busy;
      @(posedge clk);
      if (took) break;
      @(negedge clk);
    end
  endtask

  // Point in front of the camera with random content
  task automatic send_scene_point();
    logic signed [31:0] zz;
    int span;
    zz = $urandom_range(50 * 65536, 65536 / 4);
    span = $urandom_range(3) == 0 ? 4 : 2;
    send_point(32'($signed(zz) / 1000 * $signed($urandom_range(span * 1000)) -
               $signed(zz) / 2 * span),
               32'($signed(zz) / 1000 * $signed($urandom_range(span * 1000)) -
               $signed(zz) / 2 * span),
               zz, $urandom_range(7) == 0 ? $urandom() : ONE_P);
  endtask

  task automatic random_phase(input int n, input int pct, input bit noisy_matrix);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 59) idle_pct = (idle_pct == 0) ? pct : 0;
      if (noisy_matrix || $urandom_range(9) == 0)
        send_point($urandom(), $urandom(), $urandom(), $urandom());
      else
        send_scene_point();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    px = '0; py = '0; pz = '0; pw = '0;
    idle_pct = 0;
    cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset matrix is all zero: every denominator is zero
    send_point(ONE_P, ONE_P, ONE_P, ONE_P);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
    drain();

    // Directed points through a plain camera
    load_camera(300, 300, 320, 240);
    send_point(0, 0, 0, 0);                                   // zero denominator
    send_point(0, 0, ONE_P, ONE_P);                           // exact center
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, ONE_P, ONE_P);   // saturate both ways
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 0);
    send_point(32'hffff_fc00, 32'h0000_0400, ONE_P, 0);      // small offsets, fractional u and v
    send_point(32'(-(320 * 65536 / 300)), 0, ONE_P, 0);      // u just above 0
    send_point(32'(-(321 * 65536 / 300)), 0, ONE_P, 0);      // u just below 0
    send_point(32'(317 * 65536 / 300), 0, ONE_P, 0);         // u near cols-2
    send_point(32'(318 * 65536 / 300), 0, ONE_P, 0);         // u just below cols-2
    send_point(0, 32'(237 * 65536 / 300), ONE_P, 0);          // v near rows-2
    send_point(0, 32'(-(241 * 65536 / 300)), ONE_P, 0);       // v negative
    send_point(ONE_P, ONE_P, 32'hffff_0000, 0);               // behind the camera
    send_point(32'h0000_5555, 32'h0000_aaaa, 32'h0003_0000, 0);
    send_point(0, 0, 32'h0000_0001, 32'h0000_0001);           // tiny denominator
    drain();

    // Degenerate and largest image sizes
    write_reg(REG_COLS, 64'd2);
    write_reg(REG_ROWS, 64'd3);
    send_point(0, 0, ONE_P, 0);
    send_point(ONE_P, ONE_P, ONE_P, 0);
    drain();
    write_reg(REG_COLS, 64'd8191);
    write_reg(REG_ROWS, 64'd8191);
    random_phase(120, 0, 1'b0);

    // Wide camera, sender idling often
    load_camera(2000, 1500, 4000, 3000);
    random_phase(200, 73, 1'b0);

    // Small image, skewed matrix, light idling
    write_reg(REG_COLS, 64'd64);
    write_reg(REG_ROWS, 64'd48);
    load_camera(40, 40, 32, 24);
    write_reg(REG_ROW2_A, {32'(ONE_M >> 4), 32'(-(ONE_M >> 5))});
    write_reg(REG_ROW2_B, {32'(ONE_M >> 3), ONE_M});
    random_phase(200, 25, 1'b0);

    // Fully random matrix and points
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < NUM_PROJ; r++)
        write_reg(ppbw_reg_e'(r), {$urandom(), $urandom()});
      write_reg(REG_COLS, 64'($urandom_range(8191, 2)));
      write_reg(REG_ROWS, 64'($urandom_range(8191, 2)));
      random_phase(70, k == 1 ? 73 : 0, 1'b1);
    end

    // Back to a normal camera with default-size image
    write_reg(REG_COLS, 64'd640);
    write_reg(REG_ROWS, 64'd480);
    load_camera(500, 500, 320, 240);
    random_phase(200, 0, 1'b0);

    if (fail_count == 0)
      $display("perspective_project_bilinear_weights_core test passed");
    else
      $display("perspective_project_bilinear_weights_core test failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/ppbw_pkg.sv
hdl/ppbw_matrix.sv
hdl/ppbw_div_pipe.sv
hdl/ppbw_finish.sv
hdl/perspective_project_bilinear_weights_core.sv
test/ppbw_checker.sv
test/tb_top.sv
